### rtl/drs_pkg.sv
package drs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam int SECTORS_PER_TRACK = 12;
   localparam int BLOCK_W = 14;
   localparam int UNIT_SHIFT = 13;
   localparam int SECTOR_W = 4;

   // Division by the sector count is a multiply by a rounded-up reciprocal.
   localparam int RECIP_SHIFT = 28;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + SECTORS_PER_TRACK - 1) / SECTORS_PER_TRACK);

   localparam int RESET_PERIOD = 7;
   localparam int RESET_PHASE = 6;
   localparam int ATTEMPT_W = 5;

   localparam logic [13:0] BLOCK_LIMIT_RESET = 14'd4872;
   localparam logic [4:0] RETRY_LIMIT_RESET = 5'd15;

   localparam logic [1:0] CMD_SUBMIT = 2'd0;
   localparam logic [1:0] CMD_COMPLETE = 2'd1;
   localparam logic [1:0] CMD_TIMER = 2'd2;

   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_RESET = 2'd1;
   localparam logic [1:0] KIND_DONE = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   localparam logic [1:0] FN_READ = 2'd0;
   localparam logic [1:0] FN_WRITE = 2'd1;
   localparam logic [1:0] FN_CHECK = 2'd2;

   localparam logic REJ_RANGE = 1'b0;
   localparam logic REJ_FULL = 1'b1;

   localparam logic [1:0] CSR_BLOCK_LIMIT = 2'd0;
   localparam logic [1:0] CSR_WRITE_CHECK = 2'd1;
   localparam logic [1:0] CSR_RETRY_LIMIT = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  tag;
      logic [15:0] block;
      logic [2:0]  unit;
      logic        is_read;
      logic        is_raw;
      logic [1:0]  mem_ext;
      logic [15:0] byte_count;
      logic        ctl_error;
      logic        drive_error;
      logic [15:0] remaining_words;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  out_tag;
      logic [1:0]  function_res;
      logic [15:0] disk_address;
      logic [1:0]  out_mem_ext;
      logic [14:0] word_count;
      logic        failed;
      logic [16:0] residual_bytes;
      logic        reject_reason;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  tag;
      logic [15:0] disk_address;
      logic [2:0]  unit;
      logic        is_read;
      logic        is_raw;
      logic [1:0]  mem_ext;
      logic [14:0] word_count;
   } entry_type;

   // True for the attempt numbers that call for a drive reset first.
   function automatic logic reset_attempt(input logic [ATTEMPT_W-1:0] attempt);
      logic hit;
      hit = 1'b0;
      for (int k = 0; k <= (1 << ATTEMPT_W) / RESET_PERIOD; k++) begin
         if (int'(attempt) == k * RESET_PERIOD + RESET_PHASE) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

endpackage

### rtl/drs_queue.sv
module drs_queue
   import drs_pkg::*;
(
   input  logic              clock,
   input  logic              wr_en,
   input  logic [QPTR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [QPTR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type queue_ff [QUEUE_DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= queue_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/disk_request_sequencer.sv
// Channel    Direction  Handshake           Payload
// req_       in         req_valid/req_stall req_data (req_type)
// rsp_       out        rsp_valid/rsp_stall rsp_data (rsp_type)
// csr_       in         csr_valid/csr_ready csr_index, csr_wdata
//
// An item takes two cycles: one to accept it and one to execute it against
// the head entry that the queue memory read out. A completion that retires a
// request and starts the next one takes four, as the new head must be read
// from the queue memory before its transfer result is built.
// Reset is synchronous and leaves the queue empty; no clearing pass is needed.
// The request side stalls while an item executes or waits for the single
// output register to free up.
module disk_request_sequencer
   import drs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [13:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_START = 2'd3;

   localparam int PROD_W = BLOCK_W + RECIP_W;

   logic [1:0]           state_ff, state_in;
   logic [QPTR_W-1:0]    head_ff, head_in;
   logic [QPTR_W-1:0]    tail_ff, tail_in;
   logic [QCNT_W-1:0]    count_ff, count_in;
   logic                 active_ff, active_in;
   logic                 waiting_ff, waiting_in;
   logic                 check_ff, check_in;
   logic [ATTEMPT_W-1:0] attempt_ff, attempt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;
   req_type              in_ff, in_in;
   logic [PROD_W-1:0]    prod_ff, prod_in;

   logic [13:0]          block_limit_ff;
   logic                 write_check_ff;
   logic [4:0]           retry_limit_ff;

   logic                 wr_en;
   entry_type            rd_entry;
   entry_type            new_entry;
   logic                 out_free;

   logic [BLOCK_W-1:0]   quot;
   logic [BLOCK_W-1:0]   rem_full;

   function automatic rsp_type start_rsp(input entry_type e, input logic wce, input logic cp);
      rsp_type r;
      r = '0;
      r.kind = KIND_START;
      r.out_tag = e.tag;
      if (e.is_read) begin
         r.function_res = FN_READ;
      end else if (wce && cp) begin
         r.function_res = FN_CHECK;
      end else begin
         r.function_res = FN_WRITE;
      end
      r.disk_address = e.disk_address;
      r.out_mem_ext = e.mem_ext;
      r.word_count = e.word_count;
      r.last = 1'b1;
      return r;
   endfunction

   // With write check on, a write alternates between its write and check passes.
   function automatic logic check_after(input entry_type e, input logic wce, input logic cp);
      return (e.is_read || !wce) ? cp : !cp;
   endfunction

   drs_queue u_queue (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (tail_ff),
      .wr_data (new_entry),
      .rd_addr (head_ff),
      .rd_data (rd_entry)
   );

   // Cylinder-surface and sector from the product registered at accept.
   assign quot = prod_ff[RECIP_SHIFT +: BLOCK_W];
   assign rem_full = in_ff.block[BLOCK_W-1:0] - BLOCK_W'(quot * SECTORS_PER_TRACK);

   always_comb begin
      new_entry = '0;
      new_entry.tag = in_ff.tag;
      new_entry.disk_address = 16'({in_ff.unit, 13'd0})
                             | 16'({quot, 4'd0})
                             | 16'(rem_full[SECTOR_W-1:0]);
      new_entry.unit = in_ff.unit;
      new_entry.is_read = in_ff.is_read;
      new_entry.is_raw = in_ff.is_raw;
      new_entry.mem_ext = in_ff.mem_ext;
      new_entry.word_count = in_ff.byte_count[15:1];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      entry_type            head_e;
      logic                 err;
      logic [ATTEMPT_W-1:0] att_next;
      rsp_type              r;

      state_in = state_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      count_in = count_ff;
      active_in = active_ff;
      waiting_in = waiting_ff;
      check_in = check_ff;
      attempt_in = attempt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in = rsp_ff;
      in_in = in_ff;
      prod_in = prod_ff;
      wr_en = 1'b0;
      head_e = rd_entry;
      err = 1'b0;
      att_next = attempt_ff + ATTEMPT_W'(1);
      r = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               in_in = req_data;
               prod_in = PROD_W'(req_data.block[BLOCK_W-1:0]) * PROD_W'(RECIP);
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               case (in_ff.cmd)
                  CMD_SUBMIT: begin
                     if (in_ff.block >= {2'b00, block_limit_ff}) begin
                        r.kind = KIND_REJECT;
                        r.out_tag = in_ff.tag;
                        r.reject_reason = REJ_RANGE;
                        r.last = 1'b1;
                        rsp_in = r;
                        rsp_valid_in = 1'b1;
                     end else if (count_ff == QCNT_W'(QUEUE_DEPTH)) begin
                        r.kind = KIND_REJECT;
                        r.out_tag = in_ff.tag;
                        r.reject_reason = REJ_FULL;
                        r.last = 1'b1;
                        rsp_in = r;
                        rsp_valid_in = 1'b1;
                     end else begin
                        wr_en = 1'b1;
                        tail_in = (tail_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                : tail_ff + QPTR_W'(1);
                        count_in = count_ff + QCNT_W'(1);
                        if (!active_ff && !waiting_ff) begin
                           // An empty queue means the new item is the head.
                           head_e = (count_ff == '0) ? new_entry : rd_entry;
                           rsp_in = start_rsp(head_e, write_check_ff, check_ff);
                           rsp_valid_in = 1'b1;
                           check_in = check_after(head_e, write_check_ff, check_ff);
                           active_in = 1'b1;
                        end
                     end
                  end
                  CMD_COMPLETE: begin
                     if (active_ff && count_ff != '0) begin
                        active_in = 1'b0;
                        err = in_ff.ctl_error
                           || (!rd_entry.is_raw && in_ff.remaining_words != 16'd0);
                        if (err) begin
                           check_in = 1'b0;
                        end
                        if (err && attempt_ff < retry_limit_ff) begin
                           attempt_in = att_next;
                           if (reset_attempt(att_next) || in_ff.drive_error) begin
                              r.kind = KIND_RESET;
                              r.out_tag = rd_entry.tag;
                              r.disk_address = {rd_entry.unit, 13'd0};
                              r.last = 1'b1;
                              rsp_in = r;
                              rsp_valid_in = 1'b1;
                              waiting_in = 1'b1;
                           end else begin
                              rsp_in = start_rsp(rd_entry, write_check_ff, 1'b0);
                              rsp_valid_in = 1'b1;
                              check_in = check_after(rd_entry, write_check_ff, 1'b0);
                              active_in = 1'b1;
                           end
                        end else if (!err && check_ff) begin
                           rsp_in = start_rsp(rd_entry, write_check_ff, check_ff);
                           rsp_valid_in = 1'b1;
                           check_in = check_after(rd_entry, write_check_ff, check_ff);
                           active_in = 1'b1;
                        end else begin
                           attempt_in = '0;
                           r.kind = KIND_DONE;
                           r.out_tag = rd_entry.tag;
                           r.failed = err;
                           r.residual_bytes = {in_ff.remaining_words, 1'b0};
                           r.last = (count_ff == QCNT_W'(1));
                           rsp_in = r;
                           rsp_valid_in = 1'b1;
                           head_in = (head_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                   : head_ff + QPTR_W'(1);
                           count_in = count_ff - QCNT_W'(1);
                           if (count_ff != QCNT_W'(1)) begin
                              state_in = ST_READ;
                           end
                        end
                     end
                  end
                  CMD_TIMER: begin
                     if (waiting_ff) begin
                        waiting_in = 1'b0;
                        if (count_ff != '0) begin
                           rsp_in = start_rsp(rd_entry, write_check_ff, check_ff);
                           rsp_valid_in = 1'b1;
                           check_in = check_after(rd_entry, write_check_ff, check_ff);
                           active_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            // The new head address reaches the queue memory in this cycle.
            state_in = ST_START;
         end
         ST_START: begin
            if (out_free) begin
               rsp_in = start_rsp(rd_entry, write_check_ff, check_ff);
               rsp_valid_in = 1'b1;
               check_in = check_after(rd_entry, write_check_ff, check_ff);
               active_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
         active_ff <= 1'b0;
         waiting_ff <= 1'b0;
         check_ff <= 1'b0;
         attempt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
         active_ff <= active_in;
         waiting_ff <= waiting_in;
         check_ff <= check_in;
         attempt_ff <= attempt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      in_ff <= in_in;
      prod_ff <= prod_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_limit_ff <= BLOCK_LIMIT_RESET;
         write_check_ff <= 1'b0;
         retry_limit_ff <= RETRY_LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLOCK_LIMIT: block_limit_ff <= csr_wdata;
            CSR_WRITE_CHECK: write_check_ff <= csr_wdata[0];
            CSR_RETRY_LIMIT: retry_limit_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

endmodule

### sim/disk_request_sequencer_tb.sv
`timescale 1ns / 1ps
module disk_request_sequencer_tb;
   import drs_pkg::*;

   localparam logic [1:0] CMD_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES = 300;
   localparam int MAX_GAP = 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_BLOCK_LIMIT;
   logic [13:0] csr_wdata = '0;

   disk_request_sequencer uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Sequencer state as seen from outside.
   logic [7:0]  q_tag   [QUEUE_DEPTH];
   logic [15:0] q_block [QUEUE_DEPTH];
   logic [2:0]  q_unit  [QUEUE_DEPTH];
   logic        q_read  [QUEUE_DEPTH];
   logic        q_raw   [QUEUE_DEPTH];
   logic [1:0]  q_mext  [QUEUE_DEPTH];
   logic [14:0] q_wc    [QUEUE_DEPTH];
   int          m_head = 0;
   int          m_tail = 0;
   int          m_count = 0;
   int          m_attempts = 0;
   bit          m_active = 1'b0;
   bit          m_waiting = 1'b0;
   bit          m_check = 1'b0;
   logic [13:0] blk_limit = BLOCK_LIMIT_RESET;
   bit          wce = 1'b0;
   logic [4:0]  retry_lim = RETRY_LIMIT_RESET;

   rsp_type     step_out [2];
   int          step_n;
   rsp_type     expected_sequencer_output [$];

   int          tx_idle_pct = 10;
   int          rx_idle_pct = 73;
   int          hold_req = 0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          failures = 0;
   int          items_sent = 0;
   int          results_checked = 0;
   int          resets_seen = 0;
   int          rejects_seen = 0;
   rsp_type     want_rsp;

   function automatic void start_transfer();
      rsp_type x;
      int h;
      logic [31:0] addr;
      if (m_count == 0) return;
      h = m_head;
      m_active = 1'b1;
      x = '0;
      x.kind = KIND_START;
      x.out_tag = q_tag[h];
      if (q_read[h]) begin
         x.function_res = FN_READ;
      end else if (wce) begin
         x.function_res = m_check ? FN_CHECK : FN_WRITE;
         m_check = !m_check;
      end else begin
         x.function_res = FN_WRITE;
      end
      // Large cylinder numbers spill into the unit bits; only 16 bits survive.
      addr = (32'(q_unit[h]) << UNIT_SHIFT)
           | ((32'(q_block[h]) / SECTORS_PER_TRACK) << SECTOR_W)
           | (32'(q_block[h]) % SECTORS_PER_TRACK);
      x.disk_address = addr[15:0];
      x.out_mem_ext = q_mext[h];
      x.word_count = q_wc[h];
      step_out[step_n] = x;
      step_n++;
   endfunction

   function automatic void predict_sequencer_output(req_type r);
      rsp_type x;
      int h;
      bit failed;
      bit retried;
      step_n = 0;
      x = '0;
      case (r.cmd)
         CMD_SUBMIT: begin
            if (r.block >= blk_limit || m_count >= QUEUE_DEPTH) begin
               x.kind = KIND_REJECT;
               x.out_tag = r.tag;
               x.reject_reason = (r.block >= blk_limit) ? REJ_RANGE : REJ_FULL;
               step_out[0] = x;
               step_n = 1;
            end else begin
               q_tag[m_tail] = r.tag;
               q_block[m_tail] = r.block;
               q_unit[m_tail] = r.unit;
               q_read[m_tail] = r.is_read;
               q_raw[m_tail] = r.is_raw;
               q_mext[m_tail] = r.mem_ext;
               q_wc[m_tail] = r.byte_count[15:1];
               m_tail = (m_tail + 1) % QUEUE_DEPTH;
               m_count++;
               if (!m_active && !m_waiting) start_transfer();
            end
         end
         CMD_COMPLETE: begin
            if (m_active && m_count > 0) begin
               h = m_head;
               m_active = 1'b0;
               failed = 1'b0;
               retried = 1'b0;
               if (r.ctl_error || (!q_raw[h] && r.remaining_words != 0)) begin
                  m_check = 1'b0;
                  if (m_attempts >= retry_lim) begin
                     failed = 1'b1;
                  end else begin
                     m_attempts++;
                     retried = 1'b1;
                     if (m_attempts % RESET_PERIOD == RESET_PHASE || r.drive_error) begin
                        x.kind = KIND_RESET;
                        x.out_tag = q_tag[h];
                        x.disk_address = 16'(q_unit[h]) << UNIT_SHIFT;
                        step_out[0] = x;
                        step_n = 1;
                        m_waiting = 1'b1;
                     end else begin
                        start_transfer();
                     end
                  end
               end
               if (!retried) begin
                  if (!failed && m_check) begin
                     start_transfer();
                  end else begin
                     m_attempts = 0;
                     x.kind = KIND_DONE;
                     x.out_tag = q_tag[h];
                     x.failed = failed;
                     x.residual_bytes = {r.remaining_words, 1'b0};
                     step_out[0] = x;
                     step_n = 1;
                     m_head = (m_head + 1) % QUEUE_DEPTH;
                     m_count--;
                     start_transfer();
                  end
               end
            end
         end
         CMD_TIMER: begin
            if (m_waiting) begin
               m_waiting = 1'b0;
               start_transfer();
            end
         end
         default: begin
         end
      endcase
      if (step_n > 0) step_out[step_n - 1].last = 1'b1;
      for (int k = 0; k < step_n; k++) expected_sequencer_output.push_back(step_out[k]);
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_sequencer_output.size() == 0) begin
            $display("%0t: result %h arrived with none expected", $time, rsp_data);
            failures++;
         end else begin
            want_rsp = expected_sequencer_output.pop_front();
            check_field("kind", 32'(want_rsp.kind), 32'(rsp_data.kind));
            check_field("out_tag", 32'(want_rsp.out_tag), 32'(rsp_data.out_tag));
            check_field("function_res", 32'(want_rsp.function_res),
                        32'(rsp_data.function_res));
            check_field("disk_address", 32'(want_rsp.disk_address),
                        32'(rsp_data.disk_address));
            check_field("out_mem_ext", 32'(want_rsp.out_mem_ext),
                        32'(rsp_data.out_mem_ext));
            check_field("word_count", 32'(want_rsp.word_count), 32'(rsp_data.word_count));
            check_field("failed", 32'(want_rsp.failed), 32'(rsp_data.failed));
            check_field("residual_bytes", 32'(want_rsp.residual_bytes),
                        32'(rsp_data.residual_bytes));
            check_field("reject_reason", 32'(want_rsp.reject_reason),
                        32'(rsp_data.reject_reason));
            check_field("last", 32'(want_rsp.last), 32'(rsp_data.last));
            results_checked++;
            if (want_rsp.kind == KIND_RESET) resets_seen++;
            if (want_rsp.kind == KIND_REJECT) rejects_seen++;
         end
      end
   end

   // Receiver side: random stall, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_req > 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rx_idle_pct);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("disk_request_sequencer_tb NOT OK");
      $finish;
   end

   task automatic send_item(req_type item);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_stall);
      predict_sequencer_output(item);
      items_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_sequencer_output.size() != 0) @(posedge clock);
      // A completion or timer can still be in flight without a result.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [13:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_BLOCK_LIMIT: blk_limit = value;
         CSR_WRITE_CHECK: wce = value[0];
         CSR_RETRY_LIMIT: retry_lim = value[4:0];
         default: begin
         end
      endcase
   endtask

   task automatic set_config(logic [13:0] limit, logic check, logic [4:0] retries);
      write_csr(CSR_BLOCK_LIMIT, limit);
      write_csr(CSR_WRITE_CHECK, 14'(check));
      write_csr(CSR_RETRY_LIMIT, 14'(retries));
      csr_valid <= 1'b0;
   endtask

   function automatic req_type submit_req(logic [7:0] tag, logic [15:0] blk, logic [2:0] unit,
                                          logic rd, logic raw, logic [1:0] mext,
                                          logic [15:0] bytes);
      req_type x;
      x = '0;
      x.cmd = CMD_SUBMIT;
      x.tag = tag;
      x.block = blk;
      x.unit = unit;
      x.is_read = rd;
      x.is_raw = raw;
      x.mem_ext = mext;
      x.byte_count = bytes;
      return x;
   endfunction

   function automatic req_type complete_req(logic ctl, logic drv, logic [15:0] rem);
      req_type x;
      x = '0;
      x.cmd = CMD_COMPLETE;
      x.ctl_error = ctl;
      x.drive_error = drv;
      x.remaining_words = rem;
      return x;
   endfunction

   function automatic req_type other_req(logic [1:0] cmd);
      req_type x;
      x = '0;
      x.cmd = cmd;
      return x;
   endfunction

   // Mostly well-formed traffic that follows the sequencer state, with some noise.
   function automatic req_type random_item(int err_pct);
      req_type x;
      logic [95:0] noise;
      int r;
      int sub_pct;
      noise = {$urandom, $urandom, $urandom};
      x = noise[$bits(req_type)-1:0];
      r = $urandom_range(99);
      sub_pct = (m_count < 4) ? 45 : 15;
      if (r >= 4) begin
         if (m_waiting) x.cmd = (r < 70) ? CMD_TIMER : CMD_SUBMIT;
         else if (m_active && r >= sub_pct) x.cmd = CMD_COMPLETE;
         else x.cmd = CMD_SUBMIT;
         if (x.cmd == CMD_SUBMIT && $urandom_range(99) < 90) begin
            x.block = 16'($urandom_range(int'(blk_limit) - 1));
         end
         if (x.cmd == CMD_COMPLETE) begin
            x.ctl_error = 1'b0;
            x.remaining_words = '0;
            if ($urandom_range(99) < err_pct) begin
               if ($urandom_range(1)) x.ctl_error = 1'b1;
               else x.remaining_words = 16'($urandom_range(65535, 1));
            end else if (q_raw[m_head] && $urandom_range(1)) begin
               x.remaining_words = 16'($urandom);
            end
            x.drive_error = ($urandom_range(99) < 15);
         end
      end
      return x;
   endfunction

   task automatic drain_queue();
      while (m_count > 0) begin
         if (m_waiting) send_item(other_req(CMD_TIMER));
         else send_item(complete_req(1'b0, 1'b0, 16'd0));
      end
      wait_idle();
   endtask

   task automatic test_directed_cases();
      send_item(other_req(CMD_UNKNOWN));
      send_item(complete_req(1'b0, 1'b0, 16'd0));
      send_item(other_req(CMD_TIMER));
      send_item(submit_req(8'hFF, 16'hFFFF, 3'd7, 1'b1, 1'b1, 2'd3, 16'hFFFF));
      send_item(submit_req(8'h00, 16'd4872, 3'd0, 1'b0, 1'b0, 2'd0, 16'd0));
      send_item(submit_req(8'hA5, 16'd0, 3'd7, 1'b1, 1'b0, 2'd3, 16'hFFFF));
      send_item(complete_req(1'b0, 1'b0, 16'd0));
      send_item(submit_req(8'h5A, 16'd4871, 3'd0, 1'b0, 1'b1, 2'd0, 16'd0));
      send_item(complete_req(1'b0, 1'b0, 16'hFFFF));
      send_item(submit_req(8'h11, 16'd12, 3'd3, 1'b0, 1'b0, 2'd1, 16'd512));
      send_item(submit_req(8'h22, 16'd2047, 3'd4, 1'b1, 1'b0, 2'd2, 16'd1));
      send_item(complete_req(1'b0, 1'b0, 16'd5));
      send_item(complete_req(1'b1, 1'b1, 16'd0));
      // This submit lands during the drive reset wait and must only be queued.
      send_item(submit_req(8'h33, 16'd100, 3'd5, 1'b1, 1'b0, 2'd0, 16'd64));
      send_item(other_req(CMD_TIMER));
      send_item(complete_req(1'b0, 1'b0, 16'd0));
      send_item(complete_req(1'b0, 1'b0, 16'd0));
      send_item(complete_req(1'b0, 1'b0, 16'h8000));
      wait_idle();
   endtask

   task automatic test_write_check_passes();
      set_config(BLOCK_LIMIT_RESET, 1'b1, RETRY_LIMIT_RESET);
      send_item(submit_req(8'h44, 16'd4000, 3'd6, 1'b0, 1'b0, 2'd2, 16'd1024));
      send_item(complete_req(1'b0, 1'b0, 16'd0));
      send_item(complete_req(1'b0, 1'b0, 16'd3));
      send_item(complete_req(1'b0, 1'b0, 16'd0));
      send_item(complete_req(1'b0, 1'b0, 16'd0));
      wait_idle();
      // With no retries allowed the first error ends the request.
      set_config(BLOCK_LIMIT_RESET, 1'b1, 5'd0);
      send_item(submit_req(8'h55, 16'd1, 3'd1, 1'b0, 1'b0, 2'd1, 16'd2));
      send_item(complete_req(1'b1, 1'b0, 16'd7));
      wait_idle();
   endtask

   task automatic test_queue_full_backpressure();
      hold_req = HOLD_CYCLES;
      for (int k = 0; k < 20; k++) begin
         send_item(submit_req(8'(k + 16), 16'(k * 37), 3'(k), k[0], k[1], 2'(k),
                              16'(k * 100)));
      end
      // The sender holds back until every result is in.
      wait_idle();
      drain_queue();
   endtask

   task automatic test_random_traffic(logic [13:0] limit, logic check, logic [4:0] retries,
                                      int count, int err_pct);
      set_config(limit, check, retries);
      repeat (count) send_item(random_item(err_pct));
      drain_queue();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      tx_idle_pct = 10;
      rx_idle_pct = 73;
      test_directed_cases();
      test_write_check_passes();
      test_queue_full_backpressure();
      test_random_traffic(BLOCK_LIMIT_RESET, 1'b0, RETRY_LIMIT_RESET, 140, 30);
      test_random_traffic(14'd8192, 1'b1, 5'd31, 140, 80);

      tx_idle_pct = 73;
      rx_idle_pct = 10;
      test_random_traffic(14'd1, 1'b0, 5'd0, 140, 50);
      test_random_traffic(14'd100, 1'b1, 5'd7, 140, 60);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      test_random_traffic(BLOCK_LIMIT_RESET, 1'b0, RETRY_LIMIT_RESET, 140, 85);
      test_random_traffic(14'd8192, 1'b1, 5'd20, 140, 25);

      wait_idle();
      $display("Sent %0d items under seven register settings and checked %0d results,",
               items_sent, results_checked);
      $display("among them %0d drive resets and %0d rejected requests.",
               resets_seen, rejects_seen);
      if (failures == 0) begin
         $display("disk_request_sequencer_tb OK");
      end else begin
         $display("disk_request_sequencer_tb NOT OK");
      end
      $finish;
   end

endmodule
